// ----- design/i2cseq_pkg.sv -----
// Shared types and widths for the 16-bit register access sequencer.
// Used by i2c_reg16_access_sequencer_core; depends on nothing else.
package i2cseq_pkg;

    localparam int STATE_W     = 4;
    localparam int ACTION_W    = 2;
    localparam int KIND_W      = 2;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 32;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam logic [7:0] MAX_ATTEMPTS_RST = 8'd8;

    // input action codes
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DONE  = 2'd2;

    // result kind codes
    localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ABORT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        tx_byte;
        logic              gen_start;
        logic              gen_stop;
        logic              do_read;
        logic              send_ack;
        logic              success;
        logic [15:0]       read_value;
        logic              last;
    } result_t;

    function automatic result_t make_result(logic [KIND_W-1:0] kind, logic [7:0] tx,
                                            logic st, logic sp, logic rd, logic ack,
                                            logic ok, logic [15:0] val);
        result_t r;
        r.kind       = kind;
        r.tx_byte    = tx;
        r.gen_start  = st;
        r.gen_stop   = sp;
        r.do_read    = rd;
        r.send_ack   = ack;
        r.success    = ok;
        r.read_value = val;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

// ----- design/i2c_reg16_access_sequencer_core.sv -----
// Top level of the 16-bit register access sequencer over a byte-level I2C engine.
// Depends on i2cseq_pkg for result type, codes and widths.
//
// Usage: requests (write/read of a 16-bit register) and byte engine completions
// both enter on the s_ channel, selected by s_tuser. Each accepted request or
// completion produces zero, one or two results on the m_ channel: byte commands,
// abort commands and access-finished reports; m_tlast marks the final result of
// each input request. The next byte command is issued only after the completion
// of the previous one arrives.
// Throughput: one request per cycle while s_tready is high; the state update is
// a single pass between the state registers and a four-entry result queue,
// which drains one result per cycle while m_tready is high. s_tready is high
// while the queue has room for two results. A stalled receiver fills the queue,
// after which s_tready drops; nothing is lost.
// cfg_data writes max_attempts (reset value 8); cfg_ready is always high, and
// writes are expected only while no access is in progress.
// Reset (aresetn low, synchronous) returns to idle, empties the queue and
// clears all held request state.
module i2c_reg16_access_sequencer_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] device_addr, [23:8] reg_address, [39:24] write_data, [40] bus_ack,
    // [48:41] read_byte, [55:49] zero
    input  logic [i2cseq_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] action
    input  logic [i2cseq_pkg::ACTION_W-1:0]  s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] tx_byte, [8] gen_start, [9] gen_stop, [10] do_read, [11] send_ack,
    // [12] success, [28:13] read_value, [31:29] zero
    output logic [i2cseq_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] kind
    output logic [i2cseq_pkg::KIND_W-1:0]    m_tuser,
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [7:0]                       cfg_data
);

    localparam int FIFO_DEPTH = i2cseq_pkg::FIFO_DEPTH;
    localparam int PTR_W      = i2cseq_pkg::FIFO_PTR_W;
    localparam int CNT_W      = i2cseq_pkg::FIFO_CNT_W;

    localparam logic [i2cseq_pkg::STATE_W-1:0] PH_IDLE = 4'd0;
    localparam logic [i2cseq_pkg::STATE_W-1:0] PH_DEV  = 4'd1;
    localparam logic [i2cseq_pkg::STATE_W-1:0] PH_REGH = 4'd2;
    localparam logic [i2cseq_pkg::STATE_W-1:0] PH_REGL = 4'd3;
    localparam logic [i2cseq_pkg::STATE_W-1:0] PH_DATH = 4'd4;
    localparam logic [i2cseq_pkg::STATE_W-1:0] PH_DATL = 4'd5;
    localparam logic [i2cseq_pkg::STATE_W-1:0] PH_DEV2 = 4'd6;
    localparam logic [i2cseq_pkg::STATE_W-1:0] PH_RDHI = 4'd7;
    localparam logic [i2cseq_pkg::STATE_W-1:0] PH_RDLO = 4'd8;

    // request fields
    logic [7:0]  in_device;
    logic [15:0] in_register;
    logic [15:0] in_data;
    logic        in_ack;
    logic [7:0]  in_rbyte;

    assign in_device   = s_tdata[7:0];
    assign in_register = s_tdata[23:8];
    assign in_data     = s_tdata[39:24];
    assign in_ack      = s_tdata[40];
    assign in_rbyte    = s_tdata[48:41];

    logic [7:0]                        max_attempts_reg;
    logic [i2cseq_pkg::STATE_W-1:0]    phase_reg, phase_next;
    logic                              is_read_reg, is_read_next;
    logic [7:0]                        attempt_reg, attempt_next;
    logic [7:0]                        device_reg, device_next;
    logic [15:0]                       register_reg, register_next;
    logic [15:0]                       data_reg, data_next;
    logic [7:0]                        high_byte_reg, high_byte_next;

    i2cseq_pkg::result_t res0, res1;
    logic [1:0]          n_res;
    logic [7:0]          attempt_inc;

    i2cseq_pkg::result_t fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                s_acc, m_acc;

    assign cfg_ready = 1'b1;
    assign s_tready  = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign s_acc     = s_tvalid && s_tready;
    assign m_tvalid  = (count_reg != '0);
    assign m_acc     = m_tvalid && m_tready;

    assign attempt_inc = (attempt_reg == 8'hFF) ? attempt_reg : attempt_reg + 8'd1;

    always_comb begin
        phase_next     = phase_reg;
        is_read_next   = is_read_reg;
        attempt_next   = attempt_reg;
        device_next    = device_reg;
        register_next  = register_reg;
        data_next      = data_reg;
        high_byte_next = high_byte_reg;
        res0  = '0;
        res1  = '0;
        n_res = 2'd0;
        if (s_tuser == i2cseq_pkg::ACT_WRITE || s_tuser == i2cseq_pkg::ACT_READ) begin
            if (phase_reg == PH_IDLE) begin
                is_read_next  = (s_tuser == i2cseq_pkg::ACT_READ);
                device_next   = in_device;
                register_next = in_register;
                data_next     = in_data;
                attempt_next  = 8'd0;
                phase_next    = PH_DEV;
                res0  = i2cseq_pkg::make_result(i2cseq_pkg::KIND_BYTE, in_device,
                                                1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
                n_res = 2'd1;
            end
        end else if (s_tuser == i2cseq_pkg::ACT_DONE && phase_reg != PH_IDLE
                     && phase_reg <= PH_RDLO) begin
            if (phase_reg == PH_RDHI) begin
                high_byte_next = in_rbyte;
                res0  = i2cseq_pkg::make_result(i2cseq_pkg::KIND_BYTE, 8'd0,
                                                1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0);
                phase_next = PH_RDLO;
                n_res = 2'd1;
            end else if (phase_reg == PH_RDLO) begin
                res0  = i2cseq_pkg::make_result(i2cseq_pkg::KIND_FINISH, 8'd0, 1'b0,
                                                1'b0, 1'b0, 1'b0, 1'b1,
                                                {high_byte_reg, in_rbyte});
                phase_next = PH_IDLE;
                n_res = 2'd1;
            end else if (!in_ack) begin
                // abort, then retry from the device byte or give up
                res0  = i2cseq_pkg::make_result(i2cseq_pkg::KIND_ABORT, 8'd0, 1'b0,
                                                1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
                attempt_next = attempt_inc;
                if (attempt_inc >= max_attempts_reg) begin
                    res1 = i2cseq_pkg::make_result(i2cseq_pkg::KIND_FINISH, 8'd0, 1'b0,
                                                   1'b0, 1'b0, 1'b0, 1'b0,
                                                   is_read_reg ? 16'hFFFF : 16'h0000);
                    phase_next = PH_IDLE;
                end else begin
                    res1 = i2cseq_pkg::make_result(i2cseq_pkg::KIND_BYTE, device_reg,
                                                   1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
                    phase_next = PH_DEV;
                end
                n_res = 2'd2;
            end else begin
                n_res = 2'd1;
                unique case (phase_reg)
                    PH_DEV: begin
                        res0 = i2cseq_pkg::make_result(i2cseq_pkg::KIND_BYTE,
                                                       register_reg[15:8], 1'b0, 1'b0,
                                                       1'b0, 1'b0, 1'b0, 16'd0);
                        phase_next = PH_REGH;
                    end
                    PH_REGH: begin
                        res0 = i2cseq_pkg::make_result(i2cseq_pkg::KIND_BYTE,
                                                       register_reg[7:0], 1'b0,
                                                       is_read_reg, 1'b0, 1'b0, 1'b0,
                                                       16'd0);
                        phase_next = PH_REGL;
                    end
                    PH_REGL: begin
                        if (is_read_reg) begin
                            res0 = i2cseq_pkg::make_result(i2cseq_pkg::KIND_BYTE,
                                                           device_reg | 8'h01, 1'b1,
                                                           1'b0, 1'b0, 1'b0, 1'b0,
                                                           16'd0);
                            phase_next = PH_DEV2;
                        end else begin
                            res0 = i2cseq_pkg::make_result(i2cseq_pkg::KIND_BYTE,
                                                           data_reg[15:8], 1'b0, 1'b0,
                                                           1'b0, 1'b0, 1'b0, 16'd0);
                            phase_next = PH_DATH;
                        end
                    end
                    PH_DATH: begin
                        res0 = i2cseq_pkg::make_result(i2cseq_pkg::KIND_BYTE,
                                                       data_reg[7:0], 1'b0, 1'b1,
                                                       1'b0, 1'b0, 1'b0, 16'd0);
                        phase_next = PH_DATL;
                    end
                    PH_DATL: begin
                        res0 = i2cseq_pkg::make_result(i2cseq_pkg::KIND_FINISH, 8'd0,
                                                       1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                                                       16'd0);
                        phase_next = PH_IDLE;
                    end
                    default: begin
                        // device byte of the read half acknowledged: read high byte
                        res0 = i2cseq_pkg::make_result(i2cseq_pkg::KIND_BYTE, 8'd0,
                                                       1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
                                                       16'd0);
                        phase_next = PH_RDHI;
                    end
                endcase
            end
        end
        if (n_res == 2'd1) begin
            res0.last = 1'b1;
        end
        if (n_res == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_attempts_reg <= i2cseq_pkg::MAX_ATTEMPTS_RST;
            phase_reg        <= PH_IDLE;
            is_read_reg      <= 1'b0;
            attempt_reg      <= 8'd0;
            device_reg       <= 8'd0;
            register_reg     <= 16'd0;
            data_reg         <= 16'd0;
            high_byte_reg    <= 8'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_attempts_reg <= cfg_data;
            end
            if (s_acc) begin
                phase_reg     <= phase_next;
                is_read_reg   <= is_read_next;
                attempt_reg   <= attempt_next;
                device_reg    <= device_next;
                register_reg  <= register_next;
                data_reg      <= data_next;
                high_byte_reg <= high_byte_next;
            end
        end
    end

    // result queue: control
    logic [1:0] push_n;
    assign push_n = s_acc ? n_res : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= PTR_W'(wr_ptr_reg + PTR_W'(push_n));
            if (m_acc) begin
                rd_ptr_reg <= PTR_W'(rd_ptr_reg + PTR_W'(1));
            end
            count_reg <= CNT_W'(count_reg + CNT_W'(push_n) - CNT_W'(m_acc));
        end
    end

    // result queue: payload
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2) begin
            fifo_reg[PTR_W'(wr_ptr_reg + PTR_W'(1))] <= res1;
        end
    end

    i2cseq_pkg::result_t head;
    assign head = fifo_reg[rd_ptr_reg];

    always_comb begin
        m_tdata        = '0;
        m_tdata[7:0]   = head.tx_byte;
        m_tdata[8]     = head.gen_start;
        m_tdata[9]     = head.gen_stop;
        m_tdata[10]    = head.do_read;
        m_tdata[11]    = head.send_ack;
        m_tdata[12]    = head.success;
        m_tdata[28:13] = head.read_value;
    end
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue count beyond depth");

    a_read_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DEV2 || phase_reg == PH_RDHI || phase_reg == PH_RDLO)
        |-> is_read_reg)
        else $error("read-half phase during a write access");

    a_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATH || phase_reg == PH_DATL) |-> !is_read_reg)
        else $error("data phase during a read access");

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && phase_reg == PH_IDLE && (s_tuser == i2cseq_pkg::ACT_WRITE
         || s_tuser == i2cseq_pkg::ACT_READ)) |=> (phase_reg == PH_DEV && m_tvalid))
        else $error("accepted request did not start an access");

endmodule

// ----- tb/tb_i2c_reg16_access_sequencer_core.sv -----
`timescale 1ns / 1ps
// Self-checking bench for i2c_reg16_access_sequencer_core: a directed table, then random
// register write/read accesses with random acks, noise, stalls and attempt limits.
// Depends on i2cseq_pkg for widths, action and result codes and the result layout.
module tb_i2c_reg16_access_sequencer_core;

    localparam logic [i2cseq_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;
    localparam int WATCHDOG_CYCLES   = 2000;
    localparam int DRAIN_CYCLES      = 8;
    localparam int ITEMS_PER_SETTING = 135;

    typedef enum logic [3:0] {
        SQ_IDLE, SQ_DEV, SQ_REGH, SQ_REGL, SQ_DATH, SQ_DATL, SQ_DEV2, SQ_RDHI, SQ_RDLO
    } seq_phase_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_BLOCKED} rx_mode_t;

    typedef struct packed {
        logic [i2cseq_pkg::ACTION_W-1:0] act;
        logic [7:0]                      dev;
        logic [15:0]                     reg_addr;
        logic [15:0]                     wr_data;
        logic                            ack;
        logic [7:0]                      rx_byte;
    } request_t;

    typedef struct packed {
        request_t            stim;
        logic                typed;
        i2cseq_pkg::result_t want;
    } plan_row_t;

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [i2cseq_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic [i2cseq_pkg::ACTION_W-1:0]    s_tuser   = '0;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [i2cseq_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [i2cseq_pkg::KIND_W-1:0]      m_tuser;
    logic                               m_tlast;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [7:0]                         cfg_data  = '0;

    // model of the sequencer state
    seq_phase_t  seq_phase  = SQ_IDLE;
    logic        rd_access  = 1'b0;
    logic [7:0]  tries      = '0;
    logic [7:0]  max_tries  = i2cseq_pkg::MAX_ATTEMPTS_RST;
    logic [7:0]  dev_q      = '0;
    logic [15:0] reg_q      = '0;
    logic [15:0] data_q     = '0;
    logic [7:0]  hi_byte    = '0;

    i2cseq_pkg::result_t expected_results[$];
    plan_row_t           plan[$];

    int errors        = 0;
    int checked       = 0;
    int items_taken   = 0;
    int ignored_taken = 0;
    int fin_ok        = 0;
    int fin_fail      = 0;
    int burst_left    = 0;
    int quiet_cycles  = 0;
    int stall_left    = 0;
    rx_mode_t stall_mode = RX_OPEN;
    logic [7:0] mid_limit;

    i2c_reg16_access_sequencer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic i2cseq_pkg::result_t blank(input logic [i2cseq_pkg::KIND_W-1:0] kind);
        i2cseq_pkg::result_t r;
        r = '0;
        r.kind = kind;
        return r;
    endfunction

    // Work out the results of one accepted request and queue them.
    task automatic advance_sequencer(input request_t rq, output int n);
        i2cseq_pkg::result_t first;
        i2cseq_pkg::result_t second;
        n = 0;
        first = blank(i2cseq_pkg::KIND_BYTE);
        second = blank(i2cseq_pkg::KIND_BYTE);
        if (rq.act == i2cseq_pkg::ACT_WRITE || rq.act == i2cseq_pkg::ACT_READ) begin
            if (seq_phase == SQ_IDLE) begin
                rd_access = (rq.act == i2cseq_pkg::ACT_READ);
                dev_q = rq.dev;
                reg_q = rq.reg_addr;
                data_q = rq.wr_data;
                tries = '0;
                seq_phase = SQ_DEV;
                first.tx_byte = rq.dev;
                first.gen_start = 1'b1;
                n = 1;
            end
        end else if (rq.act == i2cseq_pkg::ACT_DONE && seq_phase != SQ_IDLE) begin
            n = 1;
            if (seq_phase == SQ_RDHI) begin
                hi_byte = rq.rx_byte;
                first.do_read = 1'b1;
                first.gen_stop = 1'b1;
                seq_phase = SQ_RDLO;
            end else if (seq_phase == SQ_RDLO) begin
                first = blank(i2cseq_pkg::KIND_FINISH);
                first.success = 1'b1;
                first.read_value = {hi_byte, rq.rx_byte};
                seq_phase = SQ_IDLE;
            end else if (!rq.ack) begin
                // abort, then either restart from the device byte or give up
                first = blank(i2cseq_pkg::KIND_ABORT);
                if (tries != 8'hFF)
                    tries++;
                if (tries >= max_tries) begin
                    second = blank(i2cseq_pkg::KIND_FINISH);
                    second.read_value = rd_access ? 16'hFFFF : 16'h0000;
                    seq_phase = SQ_IDLE;
                end else begin
                    second.tx_byte = dev_q;
                    second.gen_start = 1'b1;
                    seq_phase = SQ_DEV;
                end
                n = 2;
            end else begin
                case (seq_phase)
                    SQ_DEV: begin
                        first.tx_byte = reg_q[15:8];
                        seq_phase = SQ_REGH;
                    end
                    SQ_REGH: begin
                        first.tx_byte = reg_q[7:0];
                        first.gen_stop = rd_access;
                        seq_phase = SQ_REGL;
                    end
                    SQ_REGL: begin
                        if (rd_access) begin
                            first.tx_byte = dev_q | 8'h01;
                            first.gen_start = 1'b1;
                            seq_phase = SQ_DEV2;
                        end else begin
                            first.tx_byte = data_q[15:8];
                            seq_phase = SQ_DATH;
                        end
                    end
                    SQ_DATH: begin
                        first.tx_byte = data_q[7:0];
                        first.gen_stop = 1'b1;
                        seq_phase = SQ_DATL;
                    end
                    SQ_DATL: begin
                        first = blank(i2cseq_pkg::KIND_FINISH);
                        first.success = 1'b1;
                        seq_phase = SQ_IDLE;
                    end
                    default: begin
                        first.do_read = 1'b1;
                        first.send_ack = 1'b1;
                        seq_phase = SQ_RDHI;
                    end
                endcase
            end
        end
        if (n == 2) begin
            expected_results.push_back(first);
            second.last = 1'b1;
            expected_results.push_back(second);
        end else if (n == 1) begin
            first.last = 1'b1;
            expected_results.push_back(first);
        end
    endtask

    // Drive one request, idling between bursts, and wait for the handshake.
    task automatic send_request(input request_t rq, output int n);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= {7'b0, rq.rx_byte, rq.ack, rq.wr_data, rq.reg_addr, rq.dev};
        s_tuser  <= rq.act;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        advance_sequencer(rq, n);
        if (n > 0)
            items_taken++;
        else
            ignored_taken++;
    endtask

    // Hold off new requests until every expected result is out.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_tries(input logic [7:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        max_tries = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input logic [i2cseq_pkg::ACTION_W-1:0] act, input logic [7:0] dev,
                           input logic [15:0] ra, input logic [15:0] wd, input logic ack,
                           input logic [7:0] rb, input logic typed,
                           input i2cseq_pkg::result_t want);
        plan_row_t row;
        row.stim.act = act;
        row.stim.dev = dev;
        row.stim.reg_addr = ra;
        row.stim.wr_data = wd;
        row.stim.ack = ack;
        row.stim.rx_byte = rb;
        row.typed = typed;
        row.want = want;
        plan.push_back(row);
    endtask

    // Random accesses under one attempt limit; finish the open access before leaving.
    task automatic run_setting(input logic [7:0] limit_val, input bit hammer_first);
        request_t rq;
        int n;
        int pick;
        int done;
        bit nack_all;
        settle();
        write_max_tries(limit_val);
        done = 0;
        nack_all = 1'b0;
        while (done < ITEMS_PER_SETTING || seq_phase != SQ_IDLE) begin
            rq.dev      = $urandom_range(0, 255);
            rq.reg_addr = $urandom_range(0, 65535);
            rq.wr_data  = $urandom_range(0, 65535);
            rq.ack      = $urandom_range(0, 1);
            rq.rx_byte  = $urandom_range(0, 255);
            pick = $urandom_range(0, 99);
            if (seq_phase == SQ_IDLE) begin
                if (pick < 88) begin
                    rq.act = pick[0] ? i2cseq_pkg::ACT_READ : i2cseq_pkg::ACT_WRITE;
                    nack_all = hammer_first || ($urandom_range(0, 19) == 0);
                    hammer_first = 1'b0;
                end else if (pick < 94) begin
                    rq.act = i2cseq_pkg::ACT_DONE;
                end else begin
                    rq.act = ACT_NONE;
                end
            end else begin
                if (pick < 90) begin
                    rq.act = i2cseq_pkg::ACT_DONE;
                    rq.ack = nack_all ? 1'b0 : ($urandom_range(0, 7) != 0);
                end else if (pick < 96) begin
                    rq.act = pick[0] ? i2cseq_pkg::ACT_READ : i2cseq_pkg::ACT_WRITE;
                end else begin
                    rq.act = ACT_NONE;
                end
            end
            send_request(rq, n);
            if (n > 0)
                done++;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // Receiver: switch between stall patterns: open, random, sparse and blocked.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = rx_mode_t'($urandom_range(0, 3));
                stall_left = (stall_mode == RX_BLOCKED) ? $urandom_range(4, 20)
                                                        : $urandom_range(10, 60);
            end
            stall_left--;
            case (stall_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_RANDOM: m_tready <= $urandom_range(0, 1);
                RX_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
                default:   m_tready <= 1'b0;
            endcase
        end
    end

    always @(posedge aclk) begin : take_result
        i2cseq_pkg::result_t got;
        i2cseq_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = blank(m_tuser);
            got.tx_byte    = m_tdata[7:0];
            got.gen_start  = m_tdata[8];
            got.gen_stop   = m_tdata[9];
            got.do_read    = m_tdata[10];
            got.send_ack   = m_tdata[11];
            got.success    = m_tdata[12];
            got.read_value = m_tdata[28:13];
            got.last       = m_tlast;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, kind %0d data 0x%0h last %0b",
                         $time, m_tuser, m_tdata, m_tlast);
            end else begin
                want = expected_results.pop_front();
                check_field("kind", want.kind, got.kind);
                check_field("tx_byte", want.tx_byte, got.tx_byte);
                check_field("gen_start", want.gen_start, got.gen_start);
                check_field("gen_stop", want.gen_stop, got.gen_stop);
                check_field("do_read", want.do_read, got.do_read);
                check_field("send_ack", want.send_ack, got.send_ack);
                check_field("success", want.success, got.success);
                check_field("read_value", want.read_value, got.read_value);
                check_field("last", want.last, got.last);
                checked++;
                if (want.kind == i2cseq_pkg::KIND_FINISH) begin
                    if (want.success)
                        fin_ok++;
                    else
                        fin_fail++;
                end
            end
        end
    end

    // Watchdog: give up when no channel moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: watchdog expired, %0d results still expected",
                     $time, expected_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        i2cseq_pkg::result_t w;
        i2cseq_pkg::result_t none;
        int n;
        int i;
        none = '0;

        // completion while idle, unused action code, then a write at the field maxima
        add_row(i2cseq_pkg::ACT_DONE, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'hA5, 1'b0, none);
        add_row(ACT_NONE, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 1'b0, none);
        w = blank(i2cseq_pkg::KIND_BYTE);
        w.tx_byte = 8'hFF;
        w.gen_start = 1'b1;
        w.last = 1'b1;
        add_row(i2cseq_pkg::ACT_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 1'b1, w);
        // request while busy is dropped
        add_row(i2cseq_pkg::ACT_READ, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, none);
        repeat (4)
            add_row(i2cseq_pkg::ACT_DONE, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b0, none);
        w = blank(i2cseq_pkg::KIND_FINISH);
        w.success = 1'b1;
        w.last = 1'b1;
        add_row(i2cseq_pkg::ACT_DONE, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b1, w);
        // read at the field minima; read-byte completions carry no ack
        w = blank(i2cseq_pkg::KIND_BYTE);
        w.gen_start = 1'b1;
        w.last = 1'b1;
        add_row(i2cseq_pkg::ACT_READ, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1, w);
        repeat (4)
            add_row(i2cseq_pkg::ACT_DONE, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b0, none);
        add_row(i2cseq_pkg::ACT_DONE, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'hFF, 1'b0, none);
        w = blank(i2cseq_pkg::KIND_FINISH);
        w.success = 1'b1;
        w.read_value = 16'hFF00;
        w.last = 1'b1;
        add_row(i2cseq_pkg::ACT_DONE, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1, w);
        // read that is never acknowledged: retries until the reset limit, then 0xFFFF
        add_row(i2cseq_pkg::ACT_READ, 8'hA4, 16'h1234, 16'h0000, 1'b1, 8'h00, 1'b0, none);
        repeat (8)
            add_row(i2cseq_pkg::ACT_DONE, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h5A, 1'b0, none);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < plan.size(); i++) begin
            send_request(plan[i].stim, n);
            if (plan[i].typed) begin
                // replace the computed value with the one typed in the table
                void'(expected_results.pop_back());
                expected_results.push_back(plan[i].want);
            end
        end

        mid_limit = $urandom_range(2, 254);
        run_setting(8'd1, 1'b0);
        run_setting(8'd255, 1'b1);
        run_setting(8'd0, 1'b0);
        run_setting(8'd3, 1'b0);
        run_setting(mid_limit, 1'b0);
        run_setting(i2cseq_pkg::MAX_ATTEMPTS_RST, 1'b0);
        settle();

        $display("Covered %0d requests with results, %0d ignored; %0d results checked",
                 items_taken, ignored_taken, checked);
        $display("Accesses done %0d, failed %0d; attempt limits 8 1 255 0 3 %0d 8",
                 fin_ok, fin_fail, mid_limit);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
